/* hdl/ehf_pkg.sv */
// Shared types, constants, code tables and helper functions of the EBCDIC hexdump formatter.
`default_nettype none

package ehf_pkg;

   localparam int BYTES_PER_LINE_DEF = 16;
   localparam int GROUP_BYTES_DEF    = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MODE_W     = 2;
   localparam logic REG_INPUT_MODE = 1'b0;

   localparam logic [MODE_W-1:0] MODE_ASCII_HEX  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EBCDIC_HEX = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_SPACE = 2'd1;
   localparam logic [1:0] STAT_ODD   = 2'd2;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       msg_end;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      SEL_HI,
      SEL_LO,
      SEL_SPACE,
      SEL_TEXT,
      SEL_NEWLINE
   } char_sel_type;

   typedef struct packed {
      logic         accept;
      logic         emit;
      char_sel_type sel;
      logic         run_last;
      logic         line_clear;
   } cmd_type;

   typedef struct packed {
      logic have;
      logic last;
      logic odd;
      logic grp_end;
      logic line_full;
      logic pad_done;
      logic text_done;
   } sts_type;

   localparam logic [7:0] A2E_ROM [0:255] = '{
      8'h00,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h25,8'h40,8'h40,8'h0D,8'h40,8'h40,
      8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,
      8'h40,8'h4F,8'h7F,8'h7B,8'h5B,8'h6C,8'h50,8'h7D,8'h4D,8'h5D,8'h5C,8'h4E,8'h6B,8'h60,8'h4B,8'h61,
      8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'h7A,8'h5E,8'h4C,8'h7E,8'h6E,8'h6F,
      8'h7C,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
      8'hD7,8'hD8,8'hD9,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'h4A,8'hE0,8'h5A,8'h5F,8'h6D,
      8'h79,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,
      8'h97,8'h98,8'h99,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'h8B,8'h6A,8'h9B,8'hA1,8'h40,
      8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,
      8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,
      8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,
      8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,
      8'h41,8'h42,8'h43,8'h44,8'h45,8'h40,8'h40,8'h46,8'h47,8'h48,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,
      8'h40,8'h57,8'h58,8'h59,8'h62,8'h63,8'h64,8'h40,8'h40,8'h65,8'h66,8'h67,8'h68,8'h69,8'h40,8'h40,
      8'h71,8'h72,8'h73,8'h74,8'h75,8'h40,8'h40,8'h76,8'h77,8'h78,8'hAA,8'hAB,8'hAC,8'hAE,8'hAF,8'hB1,
      8'h40,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'h40,8'h40,8'hB8,8'hB9,8'hBA,8'hBB,8'hBC,8'h40,8'h40
   };

   localparam logic [7:0] E2A_ROM [0:255] = '{
      8'h00,8'h01,8'h02,8'h03,8'h20,8'h09,8'h20,8'h7F,8'h20,8'h20,8'h20,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
      8'h10,8'h11,8'h12,8'h13,8'h20,8'h20,8'h08,8'h17,8'h18,8'h19,8'h20,8'h20,8'h1C,8'h1D,8'h1E,8'h1F,
      8'h20,8'h20,8'h20,8'h20,8'h20,8'h0A,8'h17,8'h1B,8'h20,8'h20,8'h20,8'h20,8'h20,8'h05,8'h06,8'h07,
      8'h20,8'h20,8'h16,8'h20,8'h20,8'h20,8'h20,8'h04,8'h20,8'h20,8'h20,8'h20,8'h14,8'h15,8'h20,8'h1A,
      8'h20,8'hC0,8'hC1,8'hC2,8'hC3,8'hC4,8'hC7,8'hC8,8'hC9,8'h20,8'h5B,8'h2E,8'h3C,8'h28,8'h2B,8'h21,
      8'h26,8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,8'hCF,8'hD1,8'hD2,8'hD3,8'h5D,8'h24,8'h2A,8'h29,8'h3B,8'h5E,
      8'h2D,8'h2F,8'hD4,8'hD5,8'hD6,8'hD9,8'hDA,8'hDB,8'hDC,8'hDD,8'h7C,8'h2C,8'h25,8'h5F,8'h3E,8'h3F,
      8'h20,8'hE0,8'hE1,8'hE2,8'hE3,8'hE4,8'hE7,8'hE8,8'hE9,8'h60,8'h3A,8'h23,8'h40,8'h27,8'h3D,8'h22,
      8'h20,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h20,8'h7B,8'h20,8'h20,8'h20,8'h20,
      8'h20,8'h6A,8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,8'h70,8'h71,8'h72,8'h20,8'h7D,8'h20,8'h20,8'h20,8'h20,
      8'h20,8'h7E,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'hEA,8'hEB,8'hEC,8'h5B,8'hED,8'hEE,
      8'h20,8'hEF,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF9,8'hFA,8'hFB,8'hFC,8'hFD,8'h5D,8'h20,8'h60,
      8'h7B,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
      8'h7D,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
      8'h5C,8'h20,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
      8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20
   };

   // Returns a valid flag in the top bit and the digit value below it.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [7:0] parse_pair(input logic [7:0] a, input logic [7:0] b);
      logic [4:0] da;
      logic [4:0] db;
      logic [7:0] vb;
      logic [7:0] r;
      da = hex_digit(a);
      db = hex_digit(b);
      vb = db[4] ? {4'd0, db[3:0]} : 8'd0;
      if (is_ws(a) || a == CH_PLUS) begin
         r = vb;
      end else if (a == CH_MINUS) begin
         r = 8'd0 - vb;
      end else if (!da[4]) begin
         r = 8'd0;
      end else if (!db[4]) begin
         r = {4'd0, da[3:0]};
      end else begin
         r = {da[3:0], db[3:0]};
      end
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
   endfunction

endpackage

`default_nettype wire

/* hdl/ehf_ctrl.sv */
// Sequencer that steps each transaction through hex digits, spacing, padding, text and newline.
`default_nettype none

module ehf_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire ehf_pkg::sts_type sts_i,
   output ehf_pkg::cmd_type     cmd_o
);
   import ehf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HI,
      ST_LO,
      ST_SP1,
      ST_SP2,
      ST_PAD,
      ST_TEXT,
      ST_NL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;
   state_type after_byte;
   logic      run_ends;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      priority if (sts_i.line_full) begin
         after_byte = ST_TEXT;
      end else if (sts_i.last) begin
         after_byte = ST_PAD;
      end else begin
         after_byte = ST_IDLE;
      end
      run_ends = !sts_i.line_full && !sts_i.last;
   end

   always_comb begin
      state_in          = state_ff;
      cmd_o.accept      = 1'b0;
      cmd_o.emit        = 1'b0;
      cmd_o.sel         = SEL_SPACE;
      cmd_o.run_last    = 1'b0;
      cmd_o.line_clear  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.accept = 1'b1;
               state_in     = ST_HI;
            end
         end
         ST_HI: begin
            if (!sts_i.have) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               cmd_o.emit = 1'b1;
               cmd_o.sel  = SEL_HI;
               state_in   = ST_LO;
            end
         end
         ST_LO: begin
            if (slot_free) begin
               cmd_o.emit = 1'b1;
               cmd_o.sel  = SEL_LO;
               if (sts_i.odd) begin
                  state_in = ST_SP1;
               end else begin
                  cmd_o.run_last = run_ends;
                  state_in       = after_byte;
               end
            end
         end
         ST_SP1: begin
            if (slot_free) begin
               cmd_o.emit = 1'b1;
               if (sts_i.grp_end) begin
                  state_in = ST_SP2;
               end else begin
                  cmd_o.run_last = run_ends;
                  state_in       = after_byte;
               end
            end
         end
         ST_SP2: begin
            if (slot_free) begin
               cmd_o.emit     = 1'b1;
               cmd_o.run_last = run_ends;
               state_in       = after_byte;
            end
         end
         ST_PAD: begin
            if (sts_i.pad_done) begin
               state_in = ST_TEXT;
            end else if (slot_free) begin
               cmd_o.emit = 1'b1;
            end
         end
         ST_TEXT: begin
            if (slot_free) begin
               cmd_o.emit = 1'b1;
               cmd_o.sel  = SEL_TEXT;
               if (sts_i.text_done) begin
                  state_in = ST_NL;
               end
            end
         end
         ST_NL: begin
            if (slot_free) begin
               cmd_o.emit       = 1'b1;
               cmd_o.sel        = SEL_NEWLINE;
               cmd_o.run_last   = 1'b1;
               cmd_o.line_clear = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd_o.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ehf_dpath.sv */
// Datapath: character decoding, pair parsing, line counters, text buffer and output register.
`default_nettype none

module ehf_dpath #(
   parameter int BYTES_PER_LINE = ehf_pkg::BYTES_PER_LINE_DEF,
   parameter int GROUP_BYTES    = ehf_pkg::GROUP_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ehf_pkg::MODE_W-1:0]    mode_i,
   input  wire ehf_pkg::req_type              req_i,
   input  wire ehf_pkg::cmd_type              cmd_i,
   output ehf_pkg::sts_type                   sts_o,
   output ehf_pkg::rsp_type                   rsp_o
);
   import ehf_pkg::*;

   localparam int IDX_W = $clog2(BYTES_PER_LINE);
   localparam int CNT_W = $clog2(BYTES_PER_LINE + 1);
   localparam int GRP_W = $clog2(GROUP_BYTES);
   localparam int GROUP_SPACES = (GROUP_BYTES % 2 == 0) ? (BYTES_PER_LINE / GROUP_BYTES)
                                                        : (BYTES_PER_LINE / (2 * GROUP_BYTES));
   localparam int FULL_WIDTH = 2 * BYTES_PER_LINE + BYTES_PER_LINE / 2 + GROUP_SPACES;
   localparam int COL_W = $clog2(FULL_WIDTH + 1);

   logic             pend_ff, pend_in;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       byte_ff;
   logic [1:0]       stat_ff;
   logic             last_ff;
   logic             have_ff;
   logic             odd_ff;
   logic             grp_end_ff;
   logic [CNT_W-1:0] count_ff;
   logic [GRP_W-1:0] grp_cnt_ff;
   logic [COL_W-1:0] col_ff;
   logic [IDX_W-1:0] idx_ff;
   rsp_type          rsp_ff;
   logic [7:0]       text_mem [BYTES_PER_LINE];

   logic             hex_mode;
   logic             dec_have;
   logic [7:0]       dec_raw;
   logic [7:0]       dec_byte;
   logic [1:0]       dec_stat;
   logic [4:0]       lone_digit;
   logic [7:0]       ebcdic;
   logic [7:0]       out_char;
   logic             grp_wrap;

   assign hex_mode   = (mode_i == MODE_ASCII_HEX) || (mode_i == MODE_EBCDIC_HEX);
   assign lone_digit = hex_digit(req_i.in_char);

   always_comb begin
      pend_in  = pend_ff;
      first_in = first_ff;
      dec_have = 1'b0;
      dec_raw  = req_i.in_char;
      dec_stat = STAT_OK;
      if (hex_mode) begin
         if (pend_ff) begin
            dec_raw  = parse_pair(first_ff, req_i.in_char);
            dec_stat = (first_ff == CH_SPACE || req_i.in_char == CH_SPACE) ? STAT_SPACE
                                                                            : STAT_OK;
            pend_in  = 1'b0;
            dec_have = 1'b1;
         end else if (req_i.in_last) begin
            dec_raw  = lone_digit[4] ? {4'd0, lone_digit[3:0]} : 8'd0;
            dec_stat = STAT_ODD;
            dec_have = 1'b1;
         end else begin
            first_in = req_i.in_char;
            pend_in  = 1'b1;
         end
      end else begin
         pend_in  = 1'b0;
         dec_have = 1'b1;
      end
      dec_byte = (mode_i == MODE_EBCDIC_HEX) ? E2A_ROM[dec_raw] : dec_raw;
      if (req_i.in_last) begin
         pend_in  = 1'b0;
         first_in = 8'd0;
      end
   end

   assign grp_wrap = (grp_cnt_ff == GRP_W'(GROUP_BYTES - 1));
   assign ebcdic   = A2E_ROM[byte_ff];

   always_comb begin
      unique case (cmd_i.sel)
         SEL_HI:      out_char = hex_char(ebcdic[7:4]);
         SEL_LO:      out_char = hex_char(ebcdic[3:0]);
         SEL_SPACE:   out_char = CH_SPACE;
         SEL_NEWLINE: out_char = CH_NEWLINE;
         default:     out_char = CH_SPACE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd_i.accept && dec_have) begin
         text_mem[count_ff[IDX_W-1:0]] <= dec_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         first_ff   <= 8'd0;
         have_ff    <= 1'b0;
         last_ff    <= 1'b0;
         count_ff   <= '0;
         grp_cnt_ff <= '0;
         col_ff     <= '0;
         idx_ff     <= '0;
      end else begin
         if (cmd_i.accept) begin
            pend_ff  <= pend_in;
            first_ff <= first_in;
            have_ff  <= dec_have;
            last_ff  <= req_i.in_last;
            byte_ff  <= dec_byte;
            stat_ff  <= dec_stat;
            if (dec_have) begin
               odd_ff     <= count_ff[0];
               grp_end_ff <= count_ff[0] && grp_wrap;
               count_ff   <= count_ff + CNT_W'(1);
               grp_cnt_ff <= grp_wrap ? '0 : grp_cnt_ff + GRP_W'(1);
            end
         end
         if (cmd_i.emit) begin
            rsp_ff.out_char <= (cmd_i.sel == SEL_TEXT) ? text_mem[idx_ff] : out_char;
            rsp_ff.run_last <= cmd_i.run_last;
            rsp_ff.msg_end  <= last_ff && (cmd_i.sel == SEL_NEWLINE);
            rsp_ff.status   <= stat_ff;
            if (cmd_i.sel == SEL_HI || cmd_i.sel == SEL_LO || cmd_i.sel == SEL_SPACE) begin
               col_ff <= col_ff + COL_W'(1);
            end
            if (cmd_i.sel == SEL_TEXT) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
         if (cmd_i.line_clear) begin
            count_ff   <= '0;
            grp_cnt_ff <= '0;
            col_ff     <= '0;
            idx_ff     <= '0;
         end
      end
   end

   assign sts_o.have      = have_ff;
   assign sts_o.last      = last_ff;
   assign sts_o.odd       = odd_ff;
   assign sts_o.grp_end   = grp_end_ff;
   assign sts_o.line_full = (count_ff == CNT_W'(BYTES_PER_LINE));
   assign sts_o.pad_done  = (col_ff >= COL_W'(FULL_WIDTH));
   assign sts_o.text_done = (({1'b0, idx_ff} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(count_ff));
   assign rsp_o           = rsp_ff;

endmodule

`default_nettype wire

/* hdl/ebcdic_hexdump_formatter_top.sv */
// Top level of the EBCDIC hexdump formatter: configuration register, sequencer and datapath.
`default_nettype none

// Turns a message, one character per transaction, into hexdump text, one character per
// result transaction. Each character transaction is accepted and then gives its result
// characters in turn: a byte gives two hex digits plus up to two spaces, and the end of a
// line adds the buffered text bytes plus the newline; the first character of a hex pair
// gives no result. When a message ends on a partial line, padding spaces come before the
// text. The output register lets the next character be taken while the last result still
// waits. The rate is set by the single output port, at most one character per cycle, and
// less while rsp_ready stalls it. input_mode sits at byte address 0 and is to be written
// only while the block is idle; the block itself does not enforce this.
module ebcdic_hexdump_formatter_top #(
   parameter int BYTES_PER_LINE = ehf_pkg::BYTES_PER_LINE_DEF,
   parameter int GROUP_BYTES    = ehf_pkg::GROUP_BYTES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire ehf_pkg::req_type                 req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output ehf_pkg::rsp_type                      rsp_payload,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [ehf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [ehf_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ehf_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import ehf_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   cmd_type           cmd;
   sts_type           sts;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_INPUT_MODE) ? CSR_DATA_W'(mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else if (psel && penable && pwrite && paddr[2] == REG_INPUT_MODE) begin
         mode_ff <= pwdata[MODE_W-1:0];
      end
   end

   ehf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   ehf_dpath #(
      .BYTES_PER_LINE (BYTES_PER_LINE),
      .GROUP_BYTES    (GROUP_BYTES)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .mode_i (mode_ff),
      .req_i  (req_payload),
      .cmd_i  (cmd),
      .sts_o  (sts),
      .rsp_o  (rsp_payload)
   );

endmodule

`default_nettype wire
